// File: hdl/rta_pkg.sv
// shared types, constants and prime table for the rational time add/subtract core
`default_nettype none
package rta_pkg;
  localparam int WORD_WIDTH = 32;
  localparam int DIGIT_WIDTH = 4;
  localparam int PRIME_COUNT = 256;
  localparam int PRIME_WIDTH = 11;
  localparam int PIDX_WIDTH = 8;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [DIGIT_WIDTH-1:0] digit_t;
  typedef logic [PRIME_WIDTH-1:0] prime_t;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_SUB = 1'b1;

  function automatic prime_t prime_at(input logic [PIDX_WIDTH-1:0] idx);
    prime_t p;
    case (idx)
      8'd0: p = 11'd2; 8'd1: p = 11'd3; 8'd2: p = 11'd5; 8'd3: p = 11'd7;
      8'd4: p = 11'd11; 8'd5: p = 11'd13; 8'd6: p = 11'd17; 8'd7: p = 11'd19;
      8'd8: p = 11'd23; 8'd9: p = 11'd29; 8'd10: p = 11'd31; 8'd11: p = 11'd37;
      8'd12: p = 11'd41; 8'd13: p = 11'd43; 8'd14: p = 11'd47; 8'd15: p = 11'd53;
      8'd16: p = 11'd59; 8'd17: p = 11'd61; 8'd18: p = 11'd67; 8'd19: p = 11'd71;
      8'd20: p = 11'd73; 8'd21: p = 11'd79; 8'd22: p = 11'd83; 8'd23: p = 11'd89;
      8'd24: p = 11'd97; 8'd25: p = 11'd101; 8'd26: p = 11'd103; 8'd27: p = 11'd107;
      8'd28: p = 11'd109; 8'd29: p = 11'd113; 8'd30: p = 11'd127; 8'd31: p = 11'd131;
      8'd32: p = 11'd137; 8'd33: p = 11'd139; 8'd34: p = 11'd149; 8'd35: p = 11'd151;
      8'd36: p = 11'd157; 8'd37: p = 11'd163; 8'd38: p = 11'd167; 8'd39: p = 11'd173;
      8'd40: p = 11'd179; 8'd41: p = 11'd181; 8'd42: p = 11'd191; 8'd43: p = 11'd193;
      8'd44: p = 11'd197; 8'd45: p = 11'd199; 8'd46: p = 11'd211; 8'd47: p = 11'd223;
      8'd48: p = 11'd227; 8'd49: p = 11'd229; 8'd50: p = 11'd233; 8'd51: p = 11'd239;
      8'd52: p = 11'd241; 8'd53: p = 11'd251; 8'd54: p = 11'd257; 8'd55: p = 11'd263;
      8'd56: p = 11'd269; 8'd57: p = 11'd271; 8'd58: p = 11'd277; 8'd59: p = 11'd281;
      8'd60: p = 11'd283; 8'd61: p = 11'd293; 8'd62: p = 11'd307; 8'd63: p = 11'd311;
      8'd64: p = 11'd313; 8'd65: p = 11'd317; 8'd66: p = 11'd331; 8'd67: p = 11'd337;
      8'd68: p = 11'd347; 8'd69: p = 11'd349; 8'd70: p = 11'd353; 8'd71: p = 11'd359;
      8'd72: p = 11'd367; 8'd73: p = 11'd373; 8'd74: p = 11'd379; 8'd75: p = 11'd383;
      8'd76: p = 11'd389; 8'd77: p = 11'd397; 8'd78: p = 11'd401; 8'd79: p = 11'd409;
      8'd80: p = 11'd419; 8'd81: p = 11'd421; 8'd82: p = 11'd431; 8'd83: p = 11'd433;
      8'd84: p = 11'd439; 8'd85: p = 11'd443; 8'd86: p = 11'd449; 8'd87: p = 11'd457;
      8'd88: p = 11'd461; 8'd89: p = 11'd463; 8'd90: p = 11'd467; 8'd91: p = 11'd479;
      8'd92: p = 11'd487; 8'd93: p = 11'd491; 8'd94: p = 11'd499; 8'd95: p = 11'd503;
      8'd96: p = 11'd509; 8'd97: p = 11'd521; 8'd98: p = 11'd523; 8'd99: p = 11'd541;
      8'd100: p = 11'd547; 8'd101: p = 11'd557; 8'd102: p = 11'd563; 8'd103: p = 11'd569;
      8'd104: p = 11'd571; 8'd105: p = 11'd577; 8'd106: p = 11'd587; 8'd107: p = 11'd593;
      8'd108: p = 11'd599; 8'd109: p = 11'd601; 8'd110: p = 11'd607; 8'd111: p = 11'd613;
      8'd112: p = 11'd617; 8'd113: p = 11'd619; 8'd114: p = 11'd631; 8'd115: p = 11'd641;
      8'd116: p = 11'd643; 8'd117: p = 11'd647; 8'd118: p = 11'd653; 8'd119: p = 11'd659;
      8'd120: p = 11'd661; 8'd121: p = 11'd673; 8'd122: p = 11'd677; 8'd123: p = 11'd683;
      8'd124: p = 11'd691; 8'd125: p = 11'd701; 8'd126: p = 11'd709; 8'd127: p = 11'd719;
      8'd128: p = 11'd727; 8'd129: p = 11'd733; 8'd130: p = 11'd739; 8'd131: p = 11'd743;
      8'd132: p = 11'd751; 8'd133: p = 11'd757; 8'd134: p = 11'd761; 8'd135: p = 11'd769;
      8'd136: p = 11'd773; 8'd137: p = 11'd787; 8'd138: p = 11'd797; 8'd139: p = 11'd809;
      8'd140: p = 11'd811; 8'd141: p = 11'd821; 8'd142: p = 11'd823; 8'd143: p = 11'd827;
      8'd144: p = 11'd829; 8'd145: p = 11'd839; 8'd146: p = 11'd853; 8'd147: p = 11'd857;
      8'd148: p = 11'd859; 8'd149: p = 11'd863; 8'd150: p = 11'd877; 8'd151: p = 11'd881;
      8'd152: p = 11'd883; 8'd153: p = 11'd887; 8'd154: p = 11'd907; 8'd155: p = 11'd911;
      8'd156: p = 11'd919; 8'd157: p = 11'd929; 8'd158: p = 11'd937; 8'd159: p = 11'd941;
      8'd160: p = 11'd947; 8'd161: p = 11'd953; 8'd162: p = 11'd967; 8'd163: p = 11'd971;
      8'd164: p = 11'd977; 8'd165: p = 11'd983; 8'd166: p = 11'd991; 8'd167: p = 11'd997;
      8'd168: p = 11'd1009; 8'd169: p = 11'd1013; 8'd170: p = 11'd1019; 8'd171: p = 11'd1021;
      8'd172: p = 11'd1031; 8'd173: p = 11'd1033; 8'd174: p = 11'd1039; 8'd175: p = 11'd1049;
      8'd176: p = 11'd1051; 8'd177: p = 11'd1061; 8'd178: p = 11'd1063; 8'd179: p = 11'd1069;
      8'd180: p = 11'd1087; 8'd181: p = 11'd1091; 8'd182: p = 11'd1093; 8'd183: p = 11'd1097;
      8'd184: p = 11'd1103; 8'd185: p = 11'd1109; 8'd186: p = 11'd1117; 8'd187: p = 11'd1123;
      8'd188: p = 11'd1129; 8'd189: p = 11'd1151; 8'd190: p = 11'd1153; 8'd191: p = 11'd1163;
      8'd192: p = 11'd1171; 8'd193: p = 11'd1181; 8'd194: p = 11'd1187; 8'd195: p = 11'd1193;
      8'd196: p = 11'd1201; 8'd197: p = 11'd1213; 8'd198: p = 11'd1217; 8'd199: p = 11'd1223;
      8'd200: p = 11'd1229; 8'd201: p = 11'd1231; 8'd202: p = 11'd1237; 8'd203: p = 11'd1249;
      8'd204: p = 11'd1259; 8'd205: p = 11'd1277; 8'd206: p = 11'd1279; 8'd207: p = 11'd1283;
      8'd208: p = 11'd1289; 8'd209: p = 11'd1291; 8'd210: p = 11'd1297; 8'd211: p = 11'd1301;
      8'd212: p = 11'd1303; 8'd213: p = 11'd1307; 8'd214: p = 11'd1319; 8'd215: p = 11'd1321;
      8'd216: p = 11'd1327; 8'd217: p = 11'd1361; 8'd218: p = 11'd1367; 8'd219: p = 11'd1373;
      8'd220: p = 11'd1381; 8'd221: p = 11'd1399; 8'd222: p = 11'd1409; 8'd223: p = 11'd1423;
      8'd224: p = 11'd1427; 8'd225: p = 11'd1429; 8'd226: p = 11'd1433; 8'd227: p = 11'd1439;
      8'd228: p = 11'd1447; 8'd229: p = 11'd1451; 8'd230: p = 11'd1453; 8'd231: p = 11'd1459;
      8'd232: p = 11'd1471; 8'd233: p = 11'd1481; 8'd234: p = 11'd1483; 8'd235: p = 11'd1487;
      8'd236: p = 11'd1489; 8'd237: p = 11'd1493; 8'd238: p = 11'd1499; 8'd239: p = 11'd1511;
      8'd240: p = 11'd1523; 8'd241: p = 11'd1531; 8'd242: p = 11'd1543; 8'd243: p = 11'd1549;
      8'd244: p = 11'd1553; 8'd245: p = 11'd1559; 8'd246: p = 11'd1567; 8'd247: p = 11'd1571;
      8'd248: p = 11'd1579; 8'd249: p = 11'd1583; 8'd250: p = 11'd1597; 8'd251: p = 11'd1601;
      8'd252: p = 11'd1607; 8'd253: p = 11'd1609; 8'd254: p = 11'd1613; 8'd255: p = 11'd1619;
      default: p = 11'd2;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

// File: hdl/rational_time_add_subtract_core.sv
// top level of the rational time add/subtract core with prime reduction
//
// channel  | handshake             | fields
// input    | start high, busy low  | func, a_*, b_*
// result   | done strobe, 1 cycle  | sum_value, sum_value_digits, sum_rate, sum_rate_digits
//
// a zero-value item goes straight to done; an equal-rate item only aligns digits by x10 and adds
// a general item folds digits by repeated x10 (up to 60 steps), then runs three reductions
// each reduction divides the value by each prime in turn, and the rate too when the value
// divides, on the shared bit-serial divider, restarting the scan after each common factor
// rst clears the sequencer; busy stays high from accept until the done strobe
`default_nettype none
module rational_time_add_subtract_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  output logic                 done,
  input  wire                  func,
  input  wire  rta_pkg::word_t  a_value,
  input  wire  rta_pkg::digit_t a_value_digits,
  input  wire  rta_pkg::word_t  a_rate,
  input  wire  rta_pkg::digit_t a_rate_digits,
  input  wire  rta_pkg::word_t  b_value,
  input  wire  rta_pkg::digit_t b_value_digits,
  input  wire  rta_pkg::word_t  b_rate,
  input  wire  rta_pkg::digit_t b_rate_digits,
  output rta_pkg::word_t        sum_value,
  output rta_pkg::digit_t       sum_value_digits,
  output rta_pkg::word_t        sum_rate,
  output rta_pkg::digit_t       sum_rate_digits
);
  import rta_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_RED_INIT, S_RED_TEST, S_RED_DIV, S_MUL, S_DONE
  } state_t;

  typedef enum logic [1:0] {SC_EQ, SC_GEN} scale_t;

  localparam int CNT_WIDTH = $clog2(WORD_WIDTH + 2);
  localparam int BIT_WIDTH = $clog2(WORD_WIDTH);
  localparam logic [CNT_WIDTH-1:0] DIV_STEPS = CNT_WIDTH'(WORD_WIDTH);

  state_t state;
  logic sub;
  word_t av, ar, bv, br;
  digit_t avd, ard, bvd, brd;
  scale_t smode;
  logic [1:0] sel;
  logic [1:0] red;
  logic [1:0] mstep;
  logic [DIGIT_WIDTH-1:0] cnt_digit;
  word_t m, r;
  logic neg;
  logic [PIDX_WIDTH-1:0] pidx;
  logic scan_end;
  word_t quo;
  logic [PRIME_WIDTH-1:0] rem;
  logic [CNT_WIDTH-1:0] bitc;
  logic dphase;
  word_t mq;
  logic mrem_zero;
  word_t mul_a, mul_b, mul_p, x;

  prime_t p;
  logic [PRIME_WIDTH:0] rem_sh;
  word_t div_src;
  logic [BIT_WIDTH-1:0] bit_idx;

  assign p = prime_at(pidx);
  assign div_src = dphase ? r : m;
  assign bit_idx = BIT_WIDTH'(WORD_WIDTH - 1) - bitc[BIT_WIDTH-1:0];
  assign rem_sh = {rem, div_src[bit_idx]};
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            sub <= func;
            av <= a_value; ar <= a_rate; bv <= b_value; br <= b_rate;
            avd <= a_value_digits; ard <= a_rate_digits;
            bvd <= b_value_digits; brd <= b_rate_digits;
            sel <= 2'd0;
            if (a_value == '0) begin
              sum_value <= (func == FUNC_SUB) ? word_t'(-b_value) : b_value;
              sum_value_digits <= b_value_digits;
              sum_rate <= b_rate; sum_rate_digits <= b_rate_digits;
              state <= S_DONE;
            end else if (b_value == '0) begin
              sum_value <= a_value; sum_value_digits <= a_value_digits;
              sum_rate <= a_rate; sum_rate_digits <= a_rate_digits;
              state <= S_DONE;
            end else if (a_rate == b_rate && a_rate_digits == b_rate_digits) begin
              smode <= SC_EQ;
              cnt_digit <= (a_value_digits < b_value_digits)
                           ? b_value_digits - a_value_digits
                           : a_value_digits - b_value_digits;
              sel <= (a_value_digits < b_value_digits) ? 2'd0 : 2'd2;
              state <= S_SCALE;
            end else begin
              smode <= SC_GEN;
              cnt_digit <= a_value_digits;
              state <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          // one x10 step per cycle; general order: ar, av, br, bv
          if (cnt_digit != '0) begin
            case (sel)
              2'd0: begin if (smode == SC_EQ) av <= word_t'(av * 10); else ar <= word_t'(ar * 10); end
              2'd1: av <= word_t'(av * 10);
              2'd2: begin if (smode == SC_EQ) bv <= word_t'(bv * 10); else br <= word_t'(br * 10); end
              default: bv <= word_t'(bv * 10);
            endcase
            cnt_digit <= cnt_digit - 1'b1;
          end else if (smode == SC_EQ) begin
            sum_value <= (sub == FUNC_SUB) ? word_t'(av - bv) : word_t'(av + bv);
            sum_value_digits <= (avd < bvd) ? bvd : avd;
            sum_rate <= ar; sum_rate_digits <= ard;
            state <= S_DONE;
          end else begin
            case (sel)
              2'd0: cnt_digit <= ard;
              2'd1: cnt_digit <= bvd;
              2'd2: cnt_digit <= brd;
              default: cnt_digit <= '0;
            endcase
            if (sel == 2'd3) begin
              red <= 2'd0;
              state <= S_RED_INIT;
            end
            sel <= sel + 1'b1;
          end
        end
        S_RED_INIT: begin
          case (red)
            2'd0: begin neg <= av[WORD_WIDTH-1]; m <= av[WORD_WIDTH-1] ? word_t'(-av) : av; r <= ar; end
            2'd1: begin neg <= bv[WORD_WIDTH-1]; m <= bv[WORD_WIDTH-1] ? word_t'(-bv) : bv; r <= br; end
            default: begin neg <= x[WORD_WIDTH-1]; m <= x[WORD_WIDTH-1] ? word_t'(-x) : x; r <= sum_rate; end
          endcase
          pidx <= '0; scan_end <= 1'b0;
          bitc <= '0; rem <= '0; dphase <= 1'b0;
          state <= S_RED_TEST;
        end
        S_RED_TEST: begin
          if (scan_end || (m == '0 && r == '0)) begin
            case (red)
              2'd0: begin av <= neg ? word_t'(-m) : m; ar <= r; red <= 2'd1; state <= S_RED_INIT; end
              2'd1: begin
                bv <= neg ? word_t'(-m) : m; br <= r;
                mstep <= 2'd0; state <= S_MUL;
              end
              default: begin
                sum_value <= neg ? word_t'(-m) : m; sum_rate <= r;
                sum_value_digits <= '0; sum_rate_digits <= '0;
                state <= S_DONE;
              end
            endcase
          end else begin
            state <= S_RED_DIV;
          end
        end
        S_RED_DIV: begin
          // restoring division, one quotient bit per cycle, m then r
          if (bitc != DIV_STEPS) begin
            if (rem_sh >= {1'b0, p}) begin
              rem <= PRIME_WIDTH'(rem_sh - {1'b0, p});
              quo <= {quo[WORD_WIDTH-2:0], 1'b1};
            end else begin
              rem <= rem_sh[PRIME_WIDTH-1:0];
              quo <= {quo[WORD_WIDTH-2:0], 1'b0};
            end
            bitc <= bitc + 1'b1;
          end else if (!dphase) begin
            mq <= quo; mrem_zero <= (rem == '0);
            bitc <= '0; rem <= '0;
            if (rem == '0) dphase <= 1'b1;
            else begin
              if (pidx == PIDX_WIDTH'(PRIME_COUNT-1)) scan_end <= 1'b1;
              pidx <= pidx + 1'b1;
              state <= S_RED_TEST;
            end
          end else begin
            dphase <= 1'b0; bitc <= '0; rem <= '0;
            if (mrem_zero && rem == '0) begin
              m <= mq; r <= quo; pidx <= '0;
            end else begin
              if (pidx == PIDX_WIDTH'(PRIME_COUNT-1)) scan_end <= 1'b1;
              pidx <= pidx + 1'b1;
            end
            state <= S_RED_TEST;
          end
        end
        S_MUL: begin
          // shared multiplier: rate product, cross products, combine
          case (mstep)
            2'd0: begin mul_a <= ar; mul_b <= br; end
            2'd1: begin sum_rate <= mul_p; mul_a <= av; mul_b <= br; end
            2'd2: begin x <= mul_p; mul_a <= bv; mul_b <= ar; end
            default: begin
              x <= (sub == FUNC_SUB) ? word_t'(x - mul_p) : word_t'(x + mul_p);
              red <= 2'd2;
              state <= S_RED_INIT;
            end
          endcase
          mstep <= mstep + 1'b1;
        end
        S_DONE: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy still high with done");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("done without a transaction in flight");
endmodule
`default_nettype wire

// File: bench/tb.sv
// self-checking testbench for the rational time add/subtract core
`default_nettype none
module tb;
  import rta_pkg::*;

  typedef struct {
    logic   sub;
    word_t  av;
    digit_t avd;
    word_t  ar;
    digit_t ard;
    word_t  bv;
    digit_t bvd;
    word_t  br;
    digit_t brd;
    bit     drain;
  } operands_t;

  typedef struct {
    word_t  v;
    digit_t vd;
    word_t  r;
    digit_t rd;
  } sum_t;

  localparam int IDLE_LIMIT = 2000000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   func = FUNC_ADD;
  word_t  a_value = '0;
  digit_t a_value_digits = '0;
  word_t  a_rate = 32'd1;
  digit_t a_rate_digits = '0;
  word_t  b_value = '0;
  digit_t b_value_digits = '0;
  word_t  b_rate = 32'd1;
  digit_t b_rate_digits = '0;
  logic   busy, done;
  word_t  sum_value, sum_rate;
  digit_t sum_value_digits, sum_rate_digits;

  operands_t pending_q[$];
  sum_t      sums_q[$];
  operands_t cur;
  int        primes[PRIME_COUNT];
  int        errors = 0;
  int        idle_cycles = 0;
  int        gap = 0;
  bit        took = 1'b0;

  rational_time_add_subtract_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .func(func),
    .a_value(a_value), .a_value_digits(a_value_digits), .a_rate(a_rate),
    .a_rate_digits(a_rate_digits), .b_value(b_value), .b_value_digits(b_value_digits),
    .b_rate(b_rate), .b_rate_digits(b_rate_digits), .sum_value(sum_value),
    .sum_value_digits(sum_value_digits), .sum_rate(sum_rate),
    .sum_rate_digits(sum_rate_digits)
  );

  always #4 clk = ~clk;

  function automatic bit [31:0] times_ten(bit [31:0] x, int n);
    for (int k = 0; k < n; k++) x = x * 32'd10;
    return x;
  endfunction

  task automatic reduce_pair(inout bit [31:0] v, inout bit [31:0] r);
    bit neg;
    bit [31:0] m;
    int i;
    neg = v[31];
    m = neg ? -v : v;
    i = 0;
    if (m == 0 && r == 0) return;
    while (i < PRIME_COUNT) begin
      if (m % primes[i] == 0 && r % primes[i] == 0) begin
        m = m / primes[i];
        r = r / primes[i];
        i = 0;
      end else begin
        i++;
      end
    end
    v = neg ? -m : m;
  endtask

  task automatic predict_sum(input operands_t t, output sum_t s);
    bit [31:0] av, ar, bv, br, x, y, rv, rr;
    av = t.av; ar = t.ar; bv = t.bv; br = t.br;
    if (av == 0) begin
      s.v = t.sub ? -bv : bv;
      s.vd = t.bvd; s.r = br; s.rd = t.brd;
    end else if (bv == 0) begin
      s.v = av; s.vd = t.avd; s.r = ar; s.rd = t.ard;
    end else if (ar == br && t.ard == t.brd) begin
      if (t.avd < t.bvd) begin
        av = times_ten(av, t.bvd - t.avd);
        s.vd = t.bvd;
      end else begin
        bv = times_ten(bv, t.avd - t.bvd);
        s.vd = t.avd;
      end
      s.v = t.sub ? av - bv : av + bv;
      s.r = ar; s.rd = t.ard;
    end else begin
      ar = times_ten(ar, t.avd);
      av = times_ten(av, t.ard);
      br = times_ten(br, t.bvd);
      bv = times_ten(bv, t.brd);
      reduce_pair(av, ar);
      reduce_pair(bv, br);
      rr = ar * br;
      x = av * br;
      y = bv * ar;
      rv = t.sub ? x - y : x + y;
      reduce_pair(rv, rr);
      s.v = rv; s.vd = '0; s.r = rr; s.rd = '0;
    end
  endtask

  task automatic report(string what, bit [31:0] got, bit [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // value with bias toward edges and small factors
  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return 32'd1;
      4, 5: return $urandom_range(1, 2000) * (1 << $urandom_range(0, 6));
      6: return -($urandom_range(1, 5000));
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t pick_rate();
    word_t r;
    case ($urandom_range(0, 7))
      0: r = 32'hffffffff;
      1: r = 32'd1;
      2, 3: r = $urandom_range(1, 120) * (1 << $urandom_range(0, 8));
      4: r = 32'd1 << $urandom_range(0, 31);
      default: r = $urandom;
    endcase
    return (r == 0) ? 32'd1 : r;
  endfunction

  function automatic digit_t pick_digits();
    return ($urandom_range(0, 9) == 0) ? digit_t'($urandom_range(10, 15))
                                       : digit_t'($urandom_range(0, 9));
  endfunction

  function automatic operands_t make_item(int kind);
    operands_t t;
    t.sub = 1'($urandom_range(0, 1));
    t.av = pick_value(); t.avd = pick_digits();
    t.ar = pick_rate(); t.ard = pick_digits();
    t.bv = pick_value(); t.bvd = pick_digits();
    t.br = pick_rate(); t.brd = pick_digits();
    t.drain = 1'b0;
    if (t.av == 0) t.av = 32'd3;
    if (t.bv == 0) t.bv = 32'd5;
    case (kind)
      0: t.av = '0;
      1: t.bv = '0;
      2: begin
        t.br = t.ar; t.brd = t.ard;
      end
      default: begin
        if (t.ar == t.br && t.ard == t.brd) t.br = t.br + 32'd1;
        if (t.br == 0) t.br = 32'd7;
      end
    endcase
    return t;
  endfunction

  function automatic operands_t fixed(logic s, word_t av, digit_t avd, word_t ar,
                                      digit_t ard, word_t bv, digit_t bvd, word_t br,
                                      digit_t brd);
    operands_t t;
    t.sub = s; t.av = av; t.avd = avd; t.ar = ar; t.ard = ard;
    t.bv = bv; t.bvd = bvd; t.br = br; t.brd = brd; t.drain = 1'b0;
    return t;
  endfunction

  // driver
  always @(negedge clk) begin
    logic nxt;
    nxt = start;
    if (!rst && (!start || took)) begin
      nxt = 1'b0;
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_q.size() > 0 && !(pending_q[0].drain && sums_q.size() > 0)) begin
        cur = pending_q.pop_front();
        func <= cur.sub;
        a_value <= cur.av; a_value_digits <= cur.avd;
        a_rate <= cur.ar; a_rate_digits <= cur.ard;
        b_value <= cur.bv; b_value_digits <= cur.bvd;
        b_rate <= cur.br; b_rate_digits <= cur.brd;
        nxt = 1'b1;
        case ($urandom_range(0, 19))
          0: gap <= $urandom_range(10, 60);
          1, 2, 3, 4, 5: gap <= $urandom_range(1, 3);
          default: gap <= 0;
        endcase
      end
    end
    start <= nxt;
  end

  // monitor and checker
  always @(posedge clk) begin
    operands_t t;
    sum_t s, want;
    took <= !rst && start && !busy;
    if (!rst) begin
      if (start && !busy) begin
        t.sub = func; t.av = a_value; t.avd = a_value_digits;
        t.ar = a_rate; t.ard = a_rate_digits; t.bv = b_value;
        t.bvd = b_value_digits; t.br = b_rate; t.brd = b_rate_digits;
        predict_sum(t, s);
        sums_q.push_back(s);
      end
      if (done) begin
        if (sums_q.size() == 0) begin
          report("unexpected transaction value", sum_value, '0);
        end else begin
          want = sums_q.pop_front();
          if (sum_value !== want.v) report("sum_value", sum_value, want.v);
          if (sum_value_digits !== want.vd)
            report("sum_value_digits", sum_value_digits, want.vd);
          if (sum_rate !== want.r) report("sum_rate", sum_rate, want.r);
          if (sum_rate_digits !== want.rd)
            report("sum_rate_digits", sum_rate_digits, want.rd);
        end
      end
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("rational_time_add_subtract_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n, cnt, k;
    bit is_prime;
    operands_t t;
    n = 2; cnt = 0;
    while (cnt < PRIME_COUNT) begin
      is_prime = 1'b1;
      for (k = 2; k * k <= n; k++) if (n % k == 0) is_prime = 1'b0;
      if (is_prime) begin
        primes[cnt] = n;
        cnt++;
      end
      n++;
    end

    // zero values, both orders and both operations
    pending_q.push_back(fixed(FUNC_ADD, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_q.push_back(fixed(FUNC_SUB, 0, 3, 7, 2, 32'h80000000, 9, 32'hffffffff, 9));
    pending_q.push_back(fixed(FUNC_SUB, 0, 15, 5, 15, 32'h7fffffff, 15, 3, 15));
    pending_q.push_back(fixed(FUNC_ADD, 0, 0, 9, 0, 32'hfffffff0, 4, 25, 1));
    pending_q.push_back(fixed(FUNC_SUB, 32'h80000000, 9, 32'hffffffff, 9, 0, 1, 1, 0));
    pending_q.push_back(fixed(FUNC_ADD, 32'h7fffffff, 15, 1, 15, 0, 15, 8, 15));
    // equal rates with digit alignment
    pending_q.push_back(fixed(FUNC_ADD, 12, 0, 24, 1, 5, 3, 24, 1));
    pending_q.push_back(fixed(FUNC_SUB, 7, 4, 24, 1, 9, 1, 24, 1));
    pending_q.push_back(fixed(FUNC_ADD, 32'h7fffffff, 0, 32'hffffffff, 9,
                              32'h7fffffff, 0, 32'hffffffff, 9));
    pending_q.push_back(fixed(FUNC_SUB, 32'h80000000, 0, 1, 0, 1, 15, 1, 0));
    pending_q.push_back(fixed(FUNC_ADD, 3, 15, 10, 15, 32'hffffffff, 0, 10, 15));
    // general path: common factors, extremes, wrapped rate products
    pending_q.push_back(fixed(FUNC_ADD, 1, 0, 2, 0, 1, 0, 3, 0));
    pending_q.push_back(fixed(FUNC_SUB, 6, 1, 48, 0, 10, 0, 36, 2));
    pending_q.push_back(fixed(FUNC_ADD, 32'h80000000, 0, 32'hffffffff, 0,
                              32'h7fffffff, 0, 32'hfffffffe, 0));
    pending_q.push_back(fixed(FUNC_SUB, 3, 0, 32'h10000, 0, 5, 0, 32'h10000, 1));
    pending_q.push_back(fixed(FUNC_ADD, 1619 * 1619, 0, 1619 * 3, 0, 1613, 0, 1613 * 2, 0));
    pending_q.push_back(fixed(FUNC_SUB, 32'hffffffff, 15, 32'h80000000, 9,
                              32'h80000000, 15, 32'h7fffffff, 0));

    for (int i = 0; i < 1000; i++) begin
      k = $urandom_range(0, 99);
      t = make_item(k < 35 ? 0 : k < 60 ? 1 : k < 90 ? 2 : 3);
      if (i == 500) t.drain = 1'b1;
      pending_q.push_back(t);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || start || sums_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("rational_time_add_subtract_core verification clean");
    end else begin
      $display("rational_time_add_subtract_core verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
hdl/rta_pkg.sv
hdl/rational_time_add_subtract_core.sv
bench/tb.sv
